@@ hw/rtl/sstb_pkg.sv @@
package sstb_pkg;

	localparam int ELEM_W     = 32;
	localparam int NODE_W     = 6;
	localparam int NODE_DEPTH = 1 << NODE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VISIT,
		ST_LEAF,
		ST_RET,
		ST_EMIT_LOAD,
		ST_EMIT_HOLD
	} state_t;

endpackage

@@ hw/rtl/sum_segment_tree_build_core.sv @@
// When idle, one element request loads per cycle; the one marked last starts the build.
// Build: a depth-first walk with one shared adder over the n loaded elements
// (one visit per node, one leaf read per leaf, two return steps per parent node).
// Emission: node memory read, then output register, for each of the 2*span-1 nodes.
// No request is taken from the last element until the final node is delivered.
// Reset clears the count, the walk stack pointer, the node valid bits and output valid; the
// element memory keeps its contents.
module sum_segment_tree_build_core
	import sstb_pkg::*;
#(
	parameter int MAX_ELEMENTS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [ELEM_W-1:0] element,
	input  logic                     is_last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [NODE_W-1:0]        node_index,
	output logic signed [ELEM_W-1:0] node_sum,
	output logic                     last_node
);

	localparam int EA  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW  = $clog2(MAX_ELEMENTS + 1);
	localparam int SD  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int SPW = $clog2(SD + 1);
	localparam int SIW = (SD > 1) ? $clog2(SD) : 1;

	state_t state_q, state_d;

	logic [CW-1:0]     cnt_q;
	logic [SPW-1:0]    sp_q;
	logic              out_valid_q;
	logic [NODE_DEPTH-1:0] node_vld_q;

	logic [NODE_W-1:0] cur_node_q;
	logic [EA-1:0]     cur_lo_q;
	logic [EA-1:0]     cur_hi_q;
	logic [ELEM_W-1:0] ret_q;
	logic [NODE_W-1:0] last_idx_q;
	logic [NODE_W-1:0] emit_q;
	logic              rd_vld_q;
	logic [NODE_W-1:0] out_idx_q;
	logic [ELEM_W-1:0] out_sum_q;
	logic              out_last_q;

	logic [NODE_W-1:0] stk_node_q  [SD];
	logic [EA-1:0]     stk_mid_q   [SD];
	logic [EA-1:0]     stk_hi_q    [SD];
	logic [ELEM_W-1:0] stk_left_q  [SD];
	logic              stk_phase_q [SD];

	logic              in_acc, out_acc, cnt_full, split;
	logic [CW-1:0]     n_start;
	logic [EA-1:0]     hi_start;
	logic [NODE_W:0]   last_wide;
	logic [NODE_W-1:0] last_start;
	logic [EA:0]       mid_sum;
	logic [EA-1:0]     mid;
	logic [SIW-1:0]    push_i, top_i;
	logic [ELEM_W-1:0] pair_sum;

	logic              e_we;
	logic [ELEM_W-1:0] e_rdata;
	logic              n_we;
	logic [NODE_W-1:0] n_waddr, n_raddr;
	logic [ELEM_W-1:0] n_wdata, n_rdata;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign cnt_full = (cnt_q >= CW'(MAX_ELEMENTS));
	assign n_start  = cnt_full ? cnt_q : CW'(cnt_q + CW'(1));
	assign hi_start = EA'(n_start - CW'(1));
	assign mid_sum  = {1'b0, cur_lo_q} + {1'b0, cur_hi_q};
	assign mid      = mid_sum[EA:1];
	assign split    = (cur_lo_q != cur_hi_q);
	assign push_i   = SIW'(sp_q);
	assign top_i    = SIW'(sp_q - SPW'(1));
	assign pair_sum = stk_left_q[top_i] + ret_q;
	assign e_we     = in_acc && !cnt_full;

	always_comb begin
		last_wide = '0;
		for (int b = 0; b < EA; b++) begin
			if (hi_start[b]) begin
				last_wide = ((NODE_W+1)'(1) << (b + 2)) - (NODE_W+1)'(2);
			end
		end
		last_start = NODE_W'(last_wide);
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign node_index = out_idx_q;
	assign node_sum   = out_sum_q;
	assign last_node  = out_last_q;

	sstb_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (MAX_ELEMENTS)
	) u_elem_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (EA'(cnt_q)),
		.wdata (element),
		.raddr (cur_lo_q),
		.rdata (e_rdata)
	);

	sstb_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (NODE_DEPTH)
	) u_node_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		n_we    = 1'b0;
		n_waddr = cur_node_q;
		n_wdata = e_rdata;
		n_raddr = emit_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && is_last) begin
					state_d = ST_VISIT;
				end
			end
			ST_VISIT: begin
				if (!split) begin
					state_d = ST_LEAF;
				end
			end
			ST_LEAF: begin
				n_we    = 1'b1;
				state_d = ST_RET;
			end
			ST_RET: begin
				if (sp_q == '0) begin
					n_raddr = '0;
					state_d = ST_EMIT_LOAD;
				end else if (stk_phase_q[top_i]) begin
					n_we    = 1'b1;
					n_waddr = stk_node_q[top_i];
					n_wdata = pair_sum;
				end else begin
					state_d = ST_VISIT;
				end
			end
			ST_EMIT_LOAD: begin
				state_d = ST_EMIT_HOLD;
			end
			ST_EMIT_HOLD: begin
				if (out_acc) begin
					if (out_last_q) begin
						state_d = ST_IDLE;
					end else begin
						n_raddr = NODE_W'(emit_q + NODE_W'(1));
						state_d = ST_EMIT_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
			node_vld_q  <= '0;
		end else begin
			if (in_acc) begin
				if (is_last) begin
					cnt_q      <= '0;
					node_vld_q <= '0;
				end else if (!cnt_full) begin
					cnt_q <= CW'(cnt_q + CW'(1));
				end
			end
			if (n_we) begin
				node_vld_q[n_waddr] <= 1'b1;
			end
			if (state_q == ST_VISIT && split) begin
				sp_q <= SPW'(sp_q + SPW'(1));
			end
			if (state_q == ST_RET && sp_q != '0 && stk_phase_q[top_i]) begin
				sp_q <= SPW'(sp_q - SPW'(1));
			end
			if (state_q == ST_EMIT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_q <= node_vld_q[n_raddr];
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && is_last) begin
					cur_node_q <= '0;
					cur_lo_q   <= '0;
					cur_hi_q   <= hi_start;
					last_idx_q <= last_start;
				end
			end
			ST_VISIT: begin
				if (split) begin
					stk_node_q[push_i]  <= cur_node_q;
					stk_mid_q[push_i]   <= mid;
					stk_hi_q[push_i]    <= cur_hi_q;
					stk_phase_q[push_i] <= 1'b0;
					cur_node_q <= NODE_W'({cur_node_q, 1'b0} + (NODE_W+1)'(1));
					cur_hi_q   <= mid;
				end
			end
			ST_LEAF: begin
				ret_q <= e_rdata;
			end
			ST_RET: begin
				if (sp_q == '0) begin
					emit_q <= '0;
				end else if (stk_phase_q[top_i]) begin
					ret_q <= pair_sum;
				end else begin
					stk_left_q[top_i]  <= ret_q;
					stk_phase_q[top_i] <= 1'b1;
					cur_node_q <= NODE_W'({stk_node_q[top_i], 1'b0} + (NODE_W+1)'(2));
					cur_lo_q   <= EA'(stk_mid_q[top_i] + EA'(1));
					cur_hi_q   <= stk_hi_q[top_i];
				end
			end
			ST_EMIT_LOAD: begin
				out_idx_q  <= emit_q;
				out_sum_q  <= rd_vld_q ? n_rdata : '0;
				out_last_q <= (emit_q == last_idx_q);
			end
			ST_EMIT_HOLD: begin
				if (out_acc && !out_last_q) begin
					emit_q <= NODE_W'(emit_q + NODE_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	a_out_only_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_EMIT_HOLD)
		else $error("result shown outside emission");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(SD))
		else $error("walk stack overflow");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_HOLD |-> out_idx_q <= last_idx_q)
		else $error("node index past end of tree");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_last_q |=> state_q == ST_IDLE && !out_valid_q)
		else $error("no return to idle after final node");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ELEMENTS))
		else $error("element count past capacity");

endmodule

@@ hw/rtl/sstb_ram.sv @@
module sstb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ tb/tb_sum_segment_tree_build_core.sv @@
`timescale 1ns / 1ps

module tb_sum_segment_tree_build_core
	import sstb_pkg::*;
();

	localparam int MAX_ELEMS   = 32;
	localparam int TREE_NODES  = 63;
	localparam int STIM_ITEMS  = 420;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [ELEM_W-1:0] element;
		logic                     is_last;
	} elem_req_t;

	typedef struct {
		logic [NODE_W-1:0]        node_index;
		logic signed [ELEM_W-1:0] node_sum;
		logic                     last_node;
	} node_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [ELEM_W-1:0] element = '0;
	logic                     is_last = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [NODE_W-1:0]        node_index;
	logic signed [ELEM_W-1:0] node_sum;
	logic                     last_node;

	elem_req_t    pending_reqs[$];
	node_result_t expected_nodes[$];

	logic signed [ELEM_W-1:0] held_elems[MAX_ELEMS];
	int                       held_count = 0;

	int err_count = 0;
	int reqs_taken = 0;
	int trees_built = 0;
	int overflow_trees = 0;
	int nodes_checked = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_phase = 0;

	sum_segment_tree_build_core #(
		.MAX_ELEMENTS(MAX_ELEMS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.element   (element),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.node_index(node_index),
		.node_sum  (node_sum),
		.last_node (last_node)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Build the tree over the held elements and queue every node it emits.
	function automatic void build_sum_tree(int n);
		int                       range_lo[TREE_NODES];
		int                       range_hi[TREE_NODES];
		bit                       used[TREE_NODES];
		logic signed [ELEM_W-1:0] sums[TREE_NODES];
		int                       mid;
		int                       span;
		int                       total;
		node_result_t             res;
		for (int k = 0; k < TREE_NODES; k++) begin
			used[k] = 1'b0;
			sums[k] = '0;
		end
		used[0] = 1'b1;
		range_lo[0] = 0;
		range_hi[0] = n - 1;
		for (int k = 0; k < TREE_NODES; k++) begin
			if (used[k] && range_lo[k] < range_hi[k] && 2 * k + 2 < TREE_NODES) begin
				mid = (range_lo[k] + range_hi[k]) / 2;
				used[2 * k + 1] = 1'b1;
				range_lo[2 * k + 1] = range_lo[k];
				range_hi[2 * k + 1] = mid;
				used[2 * k + 2] = 1'b1;
				range_lo[2 * k + 2] = mid + 1;
				range_hi[2 * k + 2] = range_hi[k];
			end
		end
		for (int k = TREE_NODES - 1; k >= 0; k--) begin
			if (used[k]) begin
				if (range_lo[k] == range_hi[k])
					sums[k] = held_elems[range_lo[k]];
				else
					sums[k] = sums[2 * k + 1] + sums[2 * k + 2];
			end
		end
		span = 1;
		while (span < n)
			span = span * 2;
		total = 2 * span - 1;
		if (total > TREE_NODES)
			total = TREE_NODES;
		for (int k = 0; k < total; k++) begin
			res.node_index = k[NODE_W-1:0];
			res.node_sum = sums[k];
			res.last_node = (k == total - 1);
			expected_nodes.push_back(res);
		end
	endfunction

	function automatic void absorb_element(logic signed [ELEM_W-1:0] value, logic last);
		bit dropped;
		dropped = (held_count >= MAX_ELEMS);
		if (!dropped) begin
			held_elems[held_count] = value;
			held_count++;
		end
		if (last) begin
			build_sum_tree(held_count);
			trees_built++;
			if (dropped)
				overflow_trees++;
			held_count = 0;
		end
	endfunction

	function automatic logic signed [ELEM_W-1:0] pick_element();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return -32'sd1;
			4: return $signed(32'($urandom_range(0, 15)) - 32'd8);
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic void queue_array(logic signed [ELEM_W-1:0] vals[$]);
		elem_req_t r;
		foreach (vals[i]) begin
			r.element = vals[i];
			r.is_last = (i == vals.size() - 1);
			pending_reqs.push_back(r);
		end
	endfunction

	function automatic void queue_random_array(int len);
		logic signed [ELEM_W-1:0] vals[$];
		for (int i = 0; i < len; i++)
			vals.push_back(pick_element());
		queue_array(vals);
	endfunction

	// Driver: bursts of requests separated by random gaps.
	always @(posedge clk) begin
		bit took;
		took = in_valid && !in_stall;
		if (took) begin
			absorb_element(element, is_last);
			pending_reqs.delete(0);
			reqs_taken++;
		end
		if (arst_n && !(in_valid && !took)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_reqs.size() != 0) begin
				in_valid <= 1'b1;
				element <= pending_reqs[0].element;
				is_last <= pending_reqs[0].is_last;
				if (burst_left == 0)
					burst_left = $urandom_range(1, 16);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each delivered node, stall in phases of varying density.
	always @(posedge clk) begin
		node_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_nodes.size() == 0) begin
				$error("node_index: no node expected, got %0d", node_index);
				err_count++;
			end else begin
				want = expected_nodes.pop_front();
				nodes_checked++;
				if (node_index !== want.node_index) begin
					$error("node_index: expected %0d, got %0d", want.node_index, node_index);
					err_count++;
				end
				if (node_sum !== want.node_sum) begin
					$error("node_sum: expected %0d, got %0d", want.node_sum, node_sum);
					err_count++;
				end
				if (last_node !== want.last_node) begin
					$error("last_node: expected %0b, got %0b", want.last_node, last_node);
					err_count++;
				end
			end
		end
		if (stall_phase == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_phase = $urandom_range(10, 60);
		end
		stall_phase--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_sum_segment_tree_build_core: errors");
			$finish;
		end
	end

	initial begin
		logic signed [ELEM_W-1:0] vals[$];
		int total;
		int len;

		vals = {32'sh7FFF_FFFF};
		queue_array(vals);
		vals = {32'sh8000_0000};
		queue_array(vals);
		vals = {32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		queue_array(vals);
		vals = {32'sh8000_0000, -32'sd1, 32'sd0};
		queue_array(vals);
		queue_random_array(5);
		vals = {};
		for (int i = 0; i < 8; i++)
			vals.push_back(i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
		queue_array(vals);

		total = pending_reqs.size();
		while (total < STIM_ITEMS) begin
			case ($urandom_range(0, 19))
				0, 1, 2:    len = $urandom_range(33, 36);
				3, 4, 5, 6: len = $urandom_range(9, 32);
				default:    len = $urandom_range(1, 8);
			endcase
			queue_random_array(len);
			total += len;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || expected_nodes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d requests taken, %0d trees built (%0d past a full store), %0d nodes checked",
			reqs_taken, trees_built, overflow_trees, nodes_checked);
		if (err_count == 0 && expected_nodes.size() == 0)
			$display("tb_sum_segment_tree_build_core: clean");
		else
			$display("tb_sum_segment_tree_build_core: errors");
		$finish;
	end

endmodule
